// ----- hdl/mns_pkg.sv -----
// ---------------------------------------------------------------------------
// mns_pkg: shared types and constants of the melody note sequencer
// Table geometry, field widths, command codes, timing constants, divider sizing and states.
// ---------------------------------------------------------------------------
package mns_pkg;

  // note table geometry
  localparam int NOTE_DEPTH = 64;
  localparam int NOTE_AW    = $clog2(NOTE_DEPTH);
  localparam int ENTRY_W    = 24;

  // field widths
  localparam int CMD_W    = 2;
  localparam int IDX_W    = 6;
  localparam int FREQ_W   = 16;
  localparam int DIVR_W   = 8;
  localparam int TEMPO_W  = 10;
  localparam int COUNT_W  = 7;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;

  // timing constants, one whole note at one beat per minute in ms
  localparam int WHOLE_NOTE_MS = 240000;
  localparam int ELAPSED_W     = 19;
  localparam int LEN_W         = 19;
  localparam int SCALED_W      = ELAPSED_W + 4;

  // shared restoring divider
  localparam int QUO_W     = $clog2(WHOLE_NOTE_MS + 1);
  localparam int DVS_W     = TEMPO_W;
  localparam int DIV_STEPS = QUO_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_FETCH = 6'b000010,
    S_DIV   = 6'b000100,
    S_LEN   = 6'b001000,
    S_EVAL  = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

endpackage

// ----- hdl/melody_note_sequencer.sv -----
// ---------------------------------------------------------------------------
// melody_note_sequencer: note table player driven by millisecond ticks
// Holds 64 notes in a synchronous memory and steps through a melody on ticks.
// ---------------------------------------------------------------------------
// Each input item is a command: a tick, a note write, a melody start or a stop.
// Every item produces exactly one result item carrying the tone, the frequency,
// the playing flag and the current note position after that command.
// A write, a stop or a tick while idle goes straight to the result. A start
// runs the 18-step restoring divider that forms 240000/tempo. A tick while
// playing does one memory read of the current note, runs the same 18-step
// divider forming the note length, then the length and compare steps; a note
// with divider zero skips the divider and the length step.
// One item is worked at a time; the next item is taken while a result still
// waits on the output register. The note memory has no reset; reading a note
// that was never written gives an unspecified length and frequency.
module melody_note_sequencer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // note_index[5:0], note_freq[21:6], note_divider[29:22], tempo[39:30],
  // note_count[46:40], zero pad[47]
  input  logic [mns_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd[1:0]
  input  logic [mns_pkg::CMD_W-1:0]       in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // tone_on[0], tone_freq[16:1], playing[17], note_position[24:18], zero pad[31:25]
  output logic [mns_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import mns_pkg::*;

  // field unpacking
  logic [IDX_W-1:0]   in_index;
  logic [FREQ_W-1:0]  in_freq;
  logic [DIVR_W-1:0]  in_divider;
  logic [TEMPO_W-1:0] in_tempo;
  logic [COUNT_W-1:0] in_count;
  cmd_t               in_cmd;
  logic               in_acc;

  assign in_index   = in_tdata[5:0];
  assign in_freq    = in_tdata[21:6];
  assign in_divider = in_tdata[29:22];
  assign in_tempo   = in_tdata[39:30];
  assign in_count   = in_tdata[46:40];
  assign in_cmd     = cmd_t'(in_tuser);
  assign in_acc     = in_tvalid && in_tready;

  // note memory
  logic [ENTRY_W-1:0] note_mem [NOTE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic               wr_en;

  // control and melody state
  state_t                state_r, state_nxt;
  logic                  playing_r, playing_nxt;
  logic                  in_gap_r, in_gap_nxt;
  logic [COUNT_W-1:0]    cur_note_r, cur_note_nxt;
  logic [COUNT_W-1:0]    mel_len_r, mel_len_nxt;
  logic [ELAPSED_W-1:0]  elapsed_r, elapsed_nxt;
  logic [FREQ_W-1:0]     snd_freq_r, snd_freq_nxt;
  logic [QUO_W-1:0]      whole_r, whole_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  start_op_r, start_op_nxt;

  // divider state
  logic [DVS_W-1:0]      rem_r, rem_nxt;
  logic [QUO_W-1:0]      quo_r, quo_nxt;
  logic [DVS_W-1:0]      dvs_r, dvs_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  // datapath helpers
  logic [DVS_W:0]        div_shift;
  logic                  div_ge;
  logic [DVS_W-1:0]      div_rem;
  logic [QUO_W-1:0]      div_quo;
  logic [DIVR_W-1:0]     rd_mag;
  logic                  rd_dotted;
  logic [SCALED_W-1:0]   elapsed_x10;
  logic [SCALED_W-1:0]   len_x9;
  logic [COUNT_W-1:0]    cur_note_inc;
  logic [COUNT_W-1:0]    count_sat;
  logic                  tone;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // one restoring divide step
  assign div_shift = {rem_r, quo_r[QUO_W-1]};
  assign div_ge    = (div_shift >= {1'b0, dvs_r});
  assign div_rem   = div_ge ? DVS_W'(div_shift - {1'b0, dvs_r}) : div_shift[DVS_W-1:0];
  assign div_quo   = {quo_r[QUO_W-2:0], div_ge};

  // divider magnitude and dotted flag of the fetched note
  assign rd_dotted = rd_data_r[ENTRY_W-1];
  assign rd_mag    = rd_dotted ? DIVR_W'(~rd_data_r[ENTRY_W-1:FREQ_W] + 1'b1)
                               : rd_data_r[ENTRY_W-1:FREQ_W];

  // scaled compares, 10 x elapsed against 9 x length or length
  assign elapsed_x10 = {1'b0, elapsed_r, 3'b000} + {3'b000, elapsed_r, 1'b0};
  assign len_x9      = {1'b0, len_r, 3'b000} + {4'b0000, len_r};
  assign cur_note_inc = cur_note_r + 1'b1;

  // start count saturates to the table depth
  assign count_sat = (32'(in_count) > NOTE_DEPTH) ? COUNT_W'(NOTE_DEPTH) : in_count;

  assign tone  = playing_r && !in_gap_r;
  assign wr_en = in_acc && (in_cmd == CMD_WRITE) && (32'(in_index) < NOTE_DEPTH);

  // table write on accept, read of the current note on accept
  always_ff @(posedge clk) begin
    if (wr_en) begin
      note_mem[NOTE_AW'(in_index)] <= {in_divider, in_freq};
    end
    if (in_acc) begin
      rd_data_r <= note_mem[NOTE_AW'(cur_note_r)];
    end
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    playing_nxt   = playing_r;
    in_gap_nxt    = in_gap_r;
    cur_note_nxt  = cur_note_r;
    mel_len_nxt   = mel_len_r;
    elapsed_nxt   = elapsed_r;
    snd_freq_nxt  = snd_freq_r;
    whole_nxt     = whole_r;
    len_nxt       = len_r;
    start_op_nxt  = start_op_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    dvs_nxt       = dvs_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // result taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_cmd)
            CMD_TICK: begin
              if (playing_r) begin
                if (elapsed_r != {ELAPSED_W{1'b1}}) begin
                  elapsed_nxt = elapsed_r + 1'b1;
                end
                state_nxt = S_FETCH;
              end else begin
                state_nxt = S_EMIT;
              end
            end
            CMD_WRITE: begin
              state_nxt = S_EMIT;
            end
            CMD_START: begin
              mel_len_nxt  = count_sat;
              cur_note_nxt = '0;
              in_gap_nxt   = 1'b1;
              elapsed_nxt  = {ELAPSED_W{1'b1}};
              playing_nxt  = (count_sat != '0);
              rem_nxt      = '0;
              quo_nxt      = QUO_W'(WHOLE_NOTE_MS);
              dvs_nxt      = (in_tempo == '0) ? DVS_W'(1) : in_tempo;
              step_nxt     = STEP_W'(DIV_STEPS - 1);
              start_op_nxt = 1'b1;
              state_nxt    = S_DIV;
            end
            CMD_STOP: begin
              playing_nxt = 1'b0;
              in_gap_nxt  = 1'b1;
              state_nxt   = S_EMIT;
            end
            default: begin
              state_nxt = S_EMIT;
            end
          endcase
        end
      end
      S_FETCH: begin
        if (rd_mag == '0) begin
          len_nxt   = '0;
          state_nxt = S_EVAL;
        end else begin
          rem_nxt      = '0;
          quo_nxt      = whole_r;
          dvs_nxt      = DVS_W'(rd_mag);
          step_nxt     = STEP_W'(DIV_STEPS - 1);
          start_op_nxt = 1'b0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        rem_nxt  = div_rem;
        quo_nxt  = div_quo;
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          if (start_op_r) begin
            whole_nxt = div_quo;
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_LEN;
          end
        end
      end
      S_LEN: begin
        // dotted note lasts floor(1.5 x length)
        len_nxt   = rd_dotted ? (LEN_W'(quo_r) + LEN_W'(quo_r >> 1)) : LEN_W'(quo_r);
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!in_gap_r) begin
          // tone stops at 90 percent, move to the next note
          if (elapsed_x10 >= len_x9) begin
            in_gap_nxt   = 1'b1;
            cur_note_nxt = cur_note_inc;
            if (cur_note_inc >= mel_len_r) begin
              playing_nxt = 1'b0;
            end else begin
              elapsed_nxt = '0;
            end
          end
        end else begin
          // tone starts at 10 percent
          if (elapsed_x10 >= SCALED_W'(len_r)) begin
            snd_freq_nxt = rd_data_r[FREQ_W-1:0];
            in_gap_nxt   = 1'b0;
            elapsed_nxt  = '0;
          end
        end
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {7'b0000000, cur_note_r, playing_r,
                           tone ? snd_freq_r : {FREQ_W{1'b0}}, tone};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      playing_r   <= 1'b0;
      in_gap_r    <= 1'b1;
      cur_note_r  <= '0;
      mel_len_r   <= '0;
      elapsed_r   <= '0;
      snd_freq_r  <= '0;
      whole_r     <= QUO_W'(WHOLE_NOTE_MS);
      start_op_r  <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      playing_r   <= playing_nxt;
      in_gap_r    <= in_gap_nxt;
      cur_note_r  <= cur_note_nxt;
      mel_len_r   <= mel_len_nxt;
      elapsed_r   <= elapsed_nxt;
      snd_freq_r  <= snd_freq_nxt;
      whole_r     <= whole_nxt;
      start_op_r  <= start_op_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    len_r      <= len_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    dvs_r      <= dvs_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  // a melody in progress never points past its last note
  a_note_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    playing_r |-> (cur_note_r < mel_len_r))
    else $error("current note beyond melody length");

  // the melody length never exceeds the table
  a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    32'(mel_len_r) <= NOTE_DEPTH)
    else $error("melody length beyond table depth");

  // a presented result never shows a tone without a melody
  a_tone_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r[0] || out_data_r[17]))
    else $error("tone on while not playing");

  // an accepted item is worked alone until its result is queued
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("second item taken during processing");

  // the divider never runs with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (dvs_r != '0))
    else $error("divide by zero");
`endif

endmodule
